FILE: rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is active (active-low reset).
`define TBA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Clocked assertion that is also checked during reset.
`define TBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: rtl/tba_pkg.sv
// ----------------------------------------------------------------------------
// tba_pkg
// Constants and the CORDIC arctangent table for the bearing angle core.
// ----------------------------------------------------------------------------
`default_nettype none

package tba_pkg;

  localparam int ZONE_BITS_DEF       = 6;
  localparam int ANGLE_FRAC_BITS_DEF = 8;
  localparam int STEP_CM             = 50;
  localparam int LEFT_POS            = 5;
  localparam int X_SCALE             = 125;
  localparam int CORDIC_STEPS        = 20;
  localparam int Z_FRAC              = 16;  // fraction bits of the CORDIC angle
  localparam int Z_W                 = 25;  // signed angle accumulator width

  // atan(2^-i) in 2^-16 degree, rounded to nearest
  function automatic logic [Z_W-1:0] atan_lut(input int idx);
    logic [Z_W-1:0] t;
    case (idx)
      0:       t = Z_W'(2949120);
      1:       t = Z_W'(1740967);
      2:       t = Z_W'(919879);
      3:       t = Z_W'(466945);
      4:       t = Z_W'(234379);
      5:       t = Z_W'(117304);
      6:       t = Z_W'(58666);
      7:       t = Z_W'(29335);
      8:       t = Z_W'(14668);
      9:       t = Z_W'(7334);
      10:      t = Z_W'(3667);
      11:      t = Z_W'(1833);
      12:      t = Z_W'(917);
      13:      t = Z_W'(458);
      14:      t = Z_W'(229);
      15:      t = Z_W'(115);
      16:      t = Z_W'(57);
      17:      t = Z_W'(29);
      18:      t = Z_W'(14);
      19:      t = Z_W'(7);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tba_front.sv
// ----------------------------------------------------------------------------
// tba_front
// Four-stage front end: left zone merge, circle intersection, radicand.
// ----------------------------------------------------------------------------
`default_nettype none

module tba_front import tba_pkg::*; #(
  parameter int ZONE_BITS = ZONE_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire logic [ZONE_BITS-1:0]        moving_i,
  input  wire logic [ZONE_BITS-1:0]        still_i,
  input  wire logic [ZONE_BITS-1:0]        right_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output logic [2*(ZONE_BITS+6)+31:0]      word_o,   // radicand << 32
  output logic [ZONE_BITS+5:0]             ax_o,     // |x|
  output logic [ZONE_BITS+1:0]             tag_o     // {left_zone, ok, side}
);

  localparam int ZB    = ZONE_BITS;
  localparam int R1_W  = ZB + 6;
  localparam int RAD_W = 2 * R1_W;
  localparam int V_W   = RAD_W + 32;
  localparam int XW    = 2 * ZB + 8;
  localparam int DW    = XW + 1;
  localparam int SQW   = 2 * DW;

  logic [3:0] v_q;
  logic [4:0] rdy;

  assign rdy[4] = ready_i;
  for (genvar k = 0; k < 4; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign ready_o = rdy[0];
  assign valid_o = v_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int k = 1; k < 4; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage A: left zone merge, squares, left range
  logic [ZB:0]     zsum;
  logic [ZB-1:0]   lz_d;
  logic [ZB-1:0]   lz_a_q;
  logic [2*ZB-1:0] rz2_a_q, lz2_a_q;
  logic [R1_W-1:0] r1_a_q;

  assign zsum = {1'b0, moving_i} + {1'b0, still_i};
  always_comb begin
    if (moving_i == '0 && still_i == '0) begin
      lz_d = '0;
    end else if (still_i == '0) begin
      lz_d = moving_i;
    end else if (moving_i == '0) begin
      lz_d = still_i;
    end else begin
      lz_d = zsum[ZB:1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy[0]) begin
      lz_a_q  <= lz_d;
      rz2_a_q <= right_i * right_i;
      lz2_a_q <= lz_d * lz_d;
      r1_a_q  <= R1_W'(lz_d) * R1_W'(STEP_CM);
    end
  end

  // stage B: x = 125 * (rz^2 - lz^2), r1^2
  logic signed [2*ZB:0]  diff;
  logic signed [XW-1:0]  diff_ext;
  logic signed [XW-1:0]  x_b_q;
  logic [RAD_W-1:0]      r1sq_b_q;
  logic [ZB-1:0]         lz_b_q;

  assign diff     = $signed({1'b0, rz2_a_q}) - $signed({1'b0, lz2_a_q});
  assign diff_ext = {{(XW-2*ZB-1){diff[2*ZB]}}, diff};

  always_ff @(posedge clk_i) begin
    if (v_q[0] && rdy[1]) begin
      x_b_q    <= diff_ext * $signed(XW'(X_SCALE));
      r1sq_b_q <= RAD_W'(r1_a_q) * RAD_W'(r1_a_q);
      lz_b_q   <= lz_a_q;
    end
  end

  // stage C: (x - 5)^2, side and |x|
  logic signed [DW-1:0]  dxl;
  logic signed [SQW-1:0] dxl_sq;
  logic [XW-1:0]         ax_full;
  logic [SQW-1:0]        dxl2_c_q;
  logic [RAD_W-1:0]      r1sq_c_q;
  logic [R1_W-1:0]       ax_c_q;
  logic                  side_c_q;
  logic [ZB-1:0]         lz_c_q;

  assign dxl     = {x_b_q[XW-1], x_b_q} - $signed(DW'(LEFT_POS));
  assign dxl_sq  = dxl * dxl;
  assign ax_full = x_b_q[XW-1] ? XW'(-x_b_q) : XW'(x_b_q);

  always_ff @(posedge clk_i) begin
    if (v_q[1] && rdy[2]) begin
      dxl2_c_q <= dxl_sq;
      r1sq_c_q <= r1sq_b_q;
      ax_c_q   <= ax_full[R1_W-1:0];
      side_c_q <= !(x_b_q > 0);
      lz_c_q   <= lz_b_q;
    end
  end

  // stage D: radicand and its sign
  logic                 ok;
  logic [SQW-1:0]       rad_full;
  logic [V_W-1:0]       word_q;
  logic [R1_W-1:0]      ax_q;
  logic [ZB+1:0]        tag_q;

  assign ok       = SQW'(r1sq_c_q) >= dxl2_c_q;
  assign rad_full = SQW'(r1sq_c_q) - dxl2_c_q;

  always_ff @(posedge clk_i) begin
    if (v_q[2] && rdy[3]) begin
      word_q <= ok ? {rad_full[RAD_W-1:0], 32'd0} : '0;
      ax_q   <= ok ? ax_c_q : '0;
      tag_q  <= {lz_c_q, ok, side_c_q};
    end
  end

  assign word_o = word_q;
  assign ax_o   = ax_q;
  assign tag_o  = tag_q;

endmodule

`default_nettype wire

FILE: rtl/tba_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tba_sqrt_cell
// One digit of a restoring square root: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
`default_nettype none

module tba_sqrt_cell #(
  parameter int V_W   = 56,
  parameter int YQ_W  = 28,
  parameter int AUX_W = 22
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [V_W-1:0]   word_i,
  input  wire logic [YQ_W-1:0]  root_i,
  input  wire logic [YQ_W:0]    rem_i,
  input  wire logic [AUX_W-1:0] aux_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output logic [V_W-1:0]        word_o,
  output logic [YQ_W-1:0]       root_o,
  output logic [YQ_W:0]         rem_o,
  output logic [AUX_W-1:0]      aux_o
);

  logic              v_q;
  logic [YQ_W+2:0]   rem_sh, trial, rem_sub;
  logic              ge;
  logic [V_W-1:0]    word_q;
  logic [YQ_W-1:0]   root_q;
  logic [YQ_W:0]     rem_q;
  logic [AUX_W-1:0]  aux_q;

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;

  assign rem_sh  = {rem_i, word_i[V_W-1:V_W-2]};
  assign trial   = {1'b0, root_i, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      word_q <= {word_i[V_W-3:0], 2'b00};
      root_q <= {root_i[YQ_W-2:0], ge};
      rem_q  <= ge ? rem_sub[YQ_W:0] : rem_sh[YQ_W:0];
      aux_q  <= aux_i;
    end
  end

  assign word_o = word_q;
  assign root_o = root_q;
  assign rem_o  = rem_q;
  assign aux_o  = aux_q;

endmodule

`default_nettype wire

FILE: rtl/tba_cordic_cell.sv
// ----------------------------------------------------------------------------
// tba_cordic_cell
// One vectoring CORDIC micro-rotation with a fixed shift.
// ----------------------------------------------------------------------------
`default_nettype none

module tba_cordic_cell import tba_pkg::*; #(
  parameter int CW    = 31,
  parameter int TAG_W = 8,
  parameter int STEP  = 0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire logic signed [CW-1:0] x_i,
  input  wire logic signed [CW-1:0] y_i,
  input  wire logic signed [Z_W-1:0] z_i,
  input  wire logic [TAG_W-1:0]     tag_i,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output logic signed [CW-1:0]      x_o,
  output logic signed [CW-1:0]      y_o,
  output logic signed [Z_W-1:0]     z_o,
  output logic [TAG_W-1:0]          tag_o
);

  localparam logic [Z_W-1:0] T = atan_lut(STEP);

  logic                  v_q;
  logic signed [CW-1:0]  dx, dy;
  logic                  pos;
  logic signed [CW-1:0]  x_q, y_q;
  logic signed [Z_W-1:0] z_q;
  logic [TAG_W-1:0]      tag_q;

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;

  assign dx  = y_i >>> STEP;
  assign dy  = x_i >>> STEP;
  assign pos = y_i > 0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      x_q   <= pos ? x_i + dx : x_i - dx;
      y_q   <= pos ? y_i - dy : y_i + dy;
      z_q   <= pos ? z_i + $signed(T) : z_i - $signed(T);
      tag_q <= tag_i;
    end
  end

  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;
  assign tag_o = tag_q;

endmodule

`default_nettype wire

FILE: rtl/two_range_bearing_angle_core.sv
// ----------------------------------------------------------------------------
// two_range_bearing_angle_core
// Bearing of a target from two range sensors by circle intersection.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream (s_axis_*): one transfer per reading, carrying the left
//    moving and stationary zones and the right zone.
//  - Output stream (m_axis_*): exactly one transfer per input transfer, in
//    order: bearing (2^-ANGLE_FRAC_BITS degree), side, valid_res, left_zone.
//  - Pipeline: 4 front stages + (ZONE_BITS+22) square-root cells + 20 CORDIC
//    cells + 1 output stage.
//  - Throughput: one transfer per cycle unless the output stalls; every cell
//    hands its item to the next one each cycle, so a new reading may enter on every clock.
//  - Stall: each stage holds its item while the one after it is full and
//    stalled, so empty slots close up and input is taken until the whole chain
//    is full. Nothing is dropped.
//  - Reset: rst_ni clears all stage valid flags; no results are pending and
//    the block is ready at once. The datapath keeps no state between items.
//  - A negative radicand (no intersection) gives valid_res = 0, bearing = 0.
// ----------------------------------------------------------------------------
`default_nettype none

module two_range_bearing_angle_core import tba_pkg::*; #(
  parameter int ZONE_BITS       = ZONE_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // {rt_zone, still_zone, moving_zone}, moving_zone in the low bits
  input  wire logic [((3*ZONE_BITS+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // {lt_zone, valid_res, side, bearing[15:0]}, bearing in the low bits
  output logic [((ZONE_BITS+18+7)/8)*8-1:0]        m_axis_tdata
);

  localparam int ZB     = ZONE_BITS;
  localparam int F      = ANGLE_FRAC_BITS;
  localparam int R1_W   = ZB + 6;
  localparam int YQ_W   = R1_W + Z_FRAC;
  localparam int V_W    = 2 * YQ_W;
  localparam int CW     = YQ_W + 3;
  localparam int TAG_W  = ZB + 2;
  localparam int AUX_W  = R1_W + TAG_W;
  localparam int OUT_W  = ((ZB + 18 + 7) / 8) * 8;
  localparam int ZC_W   = 23;                     // holds 90 << 16
  localparam int A_W    = ZC_W - Z_FRAC + F + 1;
  localparam int B_W    = (F + 8 > 16) ? F + 8 : 16;  // holds 180 << F and 16'hFFFF
  localparam logic [ZC_W-1:0] ZMAX    = ZC_W'(90 << Z_FRAC);
  localparam logic [ZC_W:0]   HALF    = (ZC_W+1)'(1 << (Z_FRAC - 1 - F));
  localparam logic [B_W-1:0]  NINETY  = B_W'(90 << F);

  // ---- front end -----------------------------------------------------------
  logic              fr_valid, fr_ready;
  logic [V_W-1:0]    fr_word;
  logic [R1_W-1:0]   fr_ax;
  logic [TAG_W-1:0]  fr_tag;

  tba_front #(.ZONE_BITS(ZB)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .moving_i (s_axis_tdata[ZB-1:0]),
    .still_i  (s_axis_tdata[2*ZB-1:ZB]),
    .right_i  (s_axis_tdata[3*ZB-1:2*ZB]),
    .valid_o  (fr_valid),
    .ready_i  (fr_ready),
    .word_o   (fr_word),
    .ax_o     (fr_ax),
    .tag_o    (fr_tag)
  );

  // ---- square root chain: one root bit per cell ----------------------------
  logic             sq_v    [0:YQ_W];
  logic             sq_rdy  [0:YQ_W];
  logic [V_W-1:0]   sq_word [0:YQ_W];
  logic [YQ_W-1:0]  sq_root [0:YQ_W];
  logic [YQ_W:0]    sq_rem  [0:YQ_W];
  logic [AUX_W-1:0] sq_aux  [0:YQ_W];

  assign sq_v[0]    = fr_valid;
  assign fr_ready   = sq_rdy[0];
  assign sq_word[0] = fr_word;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_aux[0]  = {fr_ax, fr_tag};

  for (genvar k = 0; k < YQ_W; k++) begin : g_sqrt
    tba_sqrt_cell #(.V_W(V_W), .YQ_W(YQ_W), .AUX_W(AUX_W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[k]),
      .ready_o (sq_rdy[k]),
      .word_i  (sq_word[k]),
      .root_i  (sq_root[k]),
      .rem_i   (sq_rem[k]),
      .aux_i   (sq_aux[k]),
      .valid_o (sq_v[k+1]),
      .ready_i (sq_rdy[k+1]),
      .word_o  (sq_word[k+1]),
      .root_o  (sq_root[k+1]),
      .rem_o   (sq_rem[k+1]),
      .aux_o   (sq_aux[k+1])
    );
  end

  // ---- CORDIC chain, starting from (y, |x|) --------------------------------
  logic                  cd_v   [0:CORDIC_STEPS];
  logic                  cd_rdy [0:CORDIC_STEPS];
  logic signed [CW-1:0]  cd_x   [0:CORDIC_STEPS];
  logic signed [CW-1:0]  cd_y   [0:CORDIC_STEPS];
  logic signed [Z_W-1:0] cd_z   [0:CORDIC_STEPS];
  logic [TAG_W-1:0]      cd_tag [0:CORDIC_STEPS];

  assign cd_v[0]      = sq_v[YQ_W];
  assign sq_rdy[YQ_W] = cd_rdy[0];
  assign cd_x[0]      = $signed(CW'(sq_root[YQ_W]));
  assign cd_y[0]      = $signed(CW'({sq_aux[YQ_W][AUX_W-1:TAG_W], {Z_FRAC{1'b0}}}));
  assign cd_z[0]      = '0;
  assign cd_tag[0]    = sq_aux[YQ_W][TAG_W-1:0];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    tba_cordic_cell #(.CW(CW), .TAG_W(TAG_W), .STEP(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cd_v[i]),
      .ready_o (cd_rdy[i]),
      .x_i     (cd_x[i]),
      .y_i     (cd_y[i]),
      .z_i     (cd_z[i]),
      .tag_i   (cd_tag[i]),
      .valid_o (cd_v[i+1]),
      .ready_i (cd_rdy[i+1]),
      .x_o     (cd_x[i+1]),
      .y_o     (cd_y[i+1]),
      .z_o     (cd_z[i+1]),
      .tag_o   (cd_tag[i+1])
    );
  end

  // ---- output stage: clamp, round, fold around 90 degrees ------------------
  logic signed [Z_W-1:0] zf;
  logic [ZC_W-1:0]       zc;
  logic [A_W-1:0]        a_rnd, a_lim;
  logic [B_W-1:0]        b_full;
  logic [15:0]           bearing_d;
  logic                  t_side, t_ok;
  logic [ZB-1:0]         t_lz;
  logic                  out_v_q;
  logic [OUT_W-1:0]      out_q;

  assign zf = cd_z[CORDIC_STEPS];
  assign {t_lz, t_ok, t_side} = cd_tag[CORDIC_STEPS];

  always_comb begin
    if (zf < 0) begin
      zc = '0;
    end else if (zf > $signed(Z_W'(ZMAX))) begin
      zc = ZMAX;
    end else begin
      zc = zf[ZC_W-1:0];
    end
    // round at full angle width, then drop the extra fraction bits
    a_rnd  = A_W'(({1'b0, zc} + HALF) >> (Z_FRAC - F));
    a_lim  = (a_rnd > A_W'(NINETY)) ? A_W'(NINETY) : a_rnd;
    b_full = t_side ? NINETY - B_W'(a_lim) : NINETY + B_W'(a_lim);
    if (!t_ok) begin
      bearing_d = '0;
    end else if (b_full > B_W'(16'hFFFF)) begin
      bearing_d = 16'hFFFF;
    end else begin
      bearing_d = b_full[15:0];
    end
  end

  assign cd_rdy[CORDIC_STEPS] = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cd_rdy[CORDIC_STEPS]) begin
      out_v_q <= cd_v[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cd_v[CORDIC_STEPS] && cd_rdy[CORDIC_STEPS]) begin
      out_q <= OUT_W'({t_lz, t_ok, t_side, bearing_d});
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

FILE: rtl/tba_checker.sv
// ----------------------------------------------------------------------------
// tba_checker
// Port-level checks for the bearing angle core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tba_checker #(
  parameter int ZONE_BITS       = 6,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [((ZONE_BITS+18+7)/8)*8-1:0]   m_axis_tdata
);

  localparam int NINETY     = 90 << ANGLE_FRAC_BITS;
  localparam int NINETY_SAT = (NINETY > 65535) ? 65535 : NINETY;

  logic [15:0] bearing;
  logic        side, ok;

  assign bearing = m_axis_tdata[15:0];
  assign side    = m_axis_tdata[16];
  assign ok      = m_axis_tdata[17];

  `TBA_ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |-> !m_axis_tvalid,
    "output valid during reset")

  `TBA_ASSERT(a_stall_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
    "stalled output transfer changed")

  `TBA_ASSERT(a_invalid_zero, clk_i, rst_ni, m_axis_tvalid && !ok |-> bearing == 16'd0,
    "no-intersection result with nonzero bearing")

  `TBA_ASSERT(a_side_half, clk_i, rst_ni,
    m_axis_tvalid && ok |->
      ((!side && 32'(bearing) >= NINETY_SAT) || (side && 32'(bearing) <= NINETY)),
    "bearing on the wrong side of 90 degrees")

endmodule

bind two_range_bearing_angle_core tba_checker #(
  .ZONE_BITS       (ZONE_BITS),
  .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_tba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: tb/two_range_bearing_angle_core_tb.sv
// ----------------------------------------------------------------------------
// two_range_bearing_angle_core_tb
// Self-checking bench for the two-sensor bearing core. A directed table
// (zone extremes, no-intersection, zero-height and on-axis readings) is
// followed by random readings, mostly with the right zone near the left zone.
// Every output transfer is compared field by field against an in-bench
// model of the circle intersection, square root and CORDIC arctangent.
// Input bursts/gaps and output stalls are random.
// ----------------------------------------------------------------------------
`default_nettype none

module two_range_bearing_angle_core_tb;
  import tba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ZB      = ZONE_BITS_DEF;
  localparam int AFB     = ANGLE_FRAC_BITS_DEF;
  localparam int IN_W    = ((3*ZB+7)/8)*8;
  localparam int OUT_W   = ((ZB+18+7)/8)*8;
  localparam int N_RAND  = 930;
  localparam int LATENCY = 53;

  typedef struct packed {
    logic [ZB-1:0] lt_zone;
    logic          valid_res;
    logic          side;
    logic [15:0]   bearing;
  } bearing_t;

  // directed row: zones, plus an exact expectation where one is typed in
  typedef struct {
    logic [ZB-1:0] moving;
    logic [ZB-1:0] still;
    logic [ZB-1:0] right;
    bit            typed;
    bearing_t      want;
  } reading_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata;  // moving_zone, still_zone, rt_zone
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;  // bearing[15:0], side, valid_res, lt_zone

  two_range_bearing_angle_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // atan(2^-i) in 2^-16 degree
  longint atan_q16 [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  bearing_t pending_bearings[$];
  int       errors;
  int       n_sent, n_checked, n_valid, n_invalid;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // bit-serial floor square root
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, one;
    res = 0;
    one = 64'd1 << 62;
    while (one > v) one >>= 2;
    while (one != 0) begin
      if (v >= res + one) begin
        v   -= res + one;
        res  = (res >> 1) + one;
      end else begin
        res >>= 1;
      end
      one >>= 2;
    end
    return res;
  endfunction

  function automatic bearing_t predict_bearing(logic [ZB-1:0] mz, logic [ZB-1:0] sz,
                                               logic [ZB-1:0] rz);
    bearing_t r;
    longint   lz, x, r1, dxl, rad, xv, yv, dx, dy, z, a, ninety;
    lz = 0;
    if (mz == 0 && sz == 0) lz = 0;
    else if (sz == 0)       lz = mz;
    else if (mz == 0)       lz = sz;
    else                    lz = (longint'(mz) + longint'(sz)) >> 1;
    x   = X_SCALE * (longint'(rz) * rz - lz * lz);
    r1  = lz * STEP_CM;
    dxl = x - LEFT_POS;
    rad = r1 * r1 - dxl * dxl;
    r.lt_zone   = lz[ZB-1:0];
    r.side      = (x > 0) ? 1'b0 : 1'b1;
    r.valid_res = (rad >= 0);
    r.bearing   = '0;
    if (rad >= 0) begin
      // vector (y, |x|) onto the x axis; z accumulates atan(|x|/y)
      xv = longint'(root_floor(longint'(rad) << 32));
      yv = ((x < 0) ? -x : x) << 16;
      z  = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = yv >>> i;
        dy = xv >>> i;
        if (yv > 0) begin
          xv += dx; yv -= dy; z += atan_q16[i];
        end else begin
          xv -= dx; yv += dy; z -= atan_q16[i];
        end
      end
      if (z < 0) z = 0;
      if (z > (longint'(90) << 16)) z = longint'(90) << 16;
      ninety = longint'(90) << AFB;
      a = (z + (longint'(1) << (15 - AFB))) >>> (16 - AFB);
      if (a > ninety) a = ninety;
      a = r.side ? ninety - a : ninety + a;
      if (a > 65535) a = 65535;
      r.bearing = a[15:0];
    end
    return r;
  endfunction

  // input handshake -> expectation; output handshake -> compare
  always @(posedge clk_i) begin
    bearing_t got, want;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      pending_bearings.push_back(predict_bearing(s_axis_tdata[ZB-1:0],
                                                 s_axis_tdata[2*ZB-1:ZB],
                                                 s_axis_tdata[3*ZB-1:2*ZB]));
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = bearing_t'(m_axis_tdata[ZB+17:0]);
      if (pending_bearings.size() == 0) begin
        $error("output transfer with nothing pending: %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_bearings.pop_front();
        n_checked++;
        if (want.valid_res) n_valid++; else n_invalid++;
        if (got.bearing !== want.bearing) begin
          $error("bearing: expected %0d, got %0d", want.bearing, got.bearing); errors++;
        end
        if (got.side !== want.side) begin
          $error("side: expected %0d, got %0d", want.side, got.side); errors++;
        end
        if (got.valid_res !== want.valid_res) begin
          $error("valid_res: expected %0d, got %0d", want.valid_res, got.valid_res);
          errors++;
        end
        if (got.lt_zone !== want.lt_zone) begin
          $error("lt_zone: expected %0d, got %0d", want.lt_zone, got.lt_zone);
          errors++;
        end
      end
    end
  end

  // receiver: stall pattern with a random mode per stretch
  initial begin
    int mode, span;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 80);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0:       m_axis_tready <= 1'b1;                      // no stalls
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ~m_axis_tready;
        endcase
      end
    end
  end

  int burst_left;

  // one transfer; valid stays high straight into the next item of a burst
  task automatic send_reading(logic [ZB-1:0] mz, logic [ZB-1:0] sz, logic [ZB-1:0] rz);
    logic [IN_W-1:0] d;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    d = '0;
    d[3*ZB-1:0] = {rz, sz, mz};
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    burst_left--;
    n_sent++;
  endtask

  reading_t directed_readings[$];

  function automatic reading_t row(int mz, int sz, int rz, bit typed = 0,
                                   int brg = 0, int sd = 0, int vr = 0, int lz = 0);
    reading_t t;
    t.moving = ZB'(mz); t.still = ZB'(sz); t.right = ZB'(rz); t.typed = typed;
    t.want.bearing = 16'(brg); t.want.side = 1'(sd); t.want.valid_res = 1'(vr);
    t.want.lt_zone = ZB'(lz);
    return t;
  endfunction

  initial begin
    logic [ZB-1:0] mz, sz, rz, lz;
    int            kind;
    reading_t      t;
    errors = 0; n_sent = 0; n_checked = 0; n_valid = 0; n_invalid = 0;
    burst_left = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;

    // all zero: no target, no intersection
    directed_readings.push_back(row(0, 0, 0, 1, 0, 1, 0, 0));
    directed_readings.push_back(row(63, 0, 0, 1, 0, 1, 0, 63));
    directed_readings.push_back(row(0, 63, 0, 1, 0, 1, 0, 63));
    directed_readings.push_back(row(0, 0, 63, 1, 0, 0, 0, 0));
    directed_readings.push_back(row(63, 63, 0, 1, 0, 1, 0, 63));
    directed_readings.push_back(row(63, 62, 0, 1, 0, 1, 0, 62));  // floor average
    directed_readings.push_back(row(1, 2, 0, 1, 0, 1, 0, 1));
    // intersecting circles, equal zones (x = 0)
    directed_readings.push_back(row(63, 63, 63));
    directed_readings.push_back(row(1, 0, 1));
    directed_readings.push_back(row(0, 1, 1));
    directed_readings.push_back(row(32, 0, 32));
    directed_readings.push_back(row(21, 42, 31));
    // mostly unequal zones, one apart or further, on both sides
    directed_readings.push_back(row(1, 0, 2));
    directed_readings.push_back(row(2, 0, 1));
    directed_readings.push_back(row(63, 0, 62));
    directed_readings.push_back(row(62, 0, 63));
    directed_readings.push_back(row(0, 0, 1));
    directed_readings.push_back(row(1, 1, 0));
    directed_readings.push_back(row(42, 21, 21));
    directed_readings.push_back(row(21, 42, 63));
    directed_readings.push_back(row(63, 63, 1));
    directed_readings.push_back(row(45, 18, 31));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_readings[i]) begin
      t = directed_readings[i];
      if (t.typed && predict_bearing(t.moving, t.still, t.right) !== t.want) begin
        $error("table row %0d: model disagrees with typed expectation", i);
        errors++;
      end
      send_reading(t.moving, t.still, t.right);
    end

    for (int n = 0; n < N_RAND; n++) begin
      kind = $urandom_range(0, 9);
      mz   = ZB'($urandom_range(0, 63));
      sz   = ($urandom_range(0, 3) == 0) ? '0 : ZB'($urandom_range(0, 63));
      if ($urandom_range(0, 4) == 0) mz = '0;
      if (mz == 0 && sz == 0) lz = '0;
      else if (sz == 0)       lz = mz;
      else if (mz == 0)       lz = sz;
      else                    lz = ZB'((7'(mz) + 7'(sz)) >> 1);
      // mostly near: right zone equal to or one off the left zone
      if (kind < 5)       rz = lz;
      else if (kind < 7)  rz = (lz == 63) ? 6'd62 : lz + 6'd1;
      else if (kind < 8)  rz = (lz == 0) ? 6'd1 : lz - 6'd1;
      else                rz = ZB'($urandom_range(0, 63));
      send_reading(mz, sz, rz);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_bearings.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);

    $display("Sent %0d readings (%0d directed), checked %0d results:",
             n_sent, directed_readings.size(), n_checked);
    $display("  %0d with intersecting circles, %0d with none", n_valid, n_invalid);
    if (errors == 0 && pending_bearings.size() == 0) begin
      $display("two_range_bearing_angle_core_tb: PASS");
    end else begin
      $display("two_range_bearing_angle_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("two_range_bearing_angle_core_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/tba_pkg.sv
rtl/tba_front.sv
rtl/tba_sqrt_cell.sv
rtl/tba_cordic_cell.sv
rtl/two_range_bearing_angle_core.sv
rtl/tba_checker.sv
tb/two_range_bearing_angle_core_tb.sv
